### rtl/u8vcf_pkg.sv
// ----------------------------------------------------------------------------
// u8vcf_pkg
// Shared constants, status codes and helpers for the UTF-8 validator with
// control character filter.
// ----------------------------------------------------------------------------
`default_nettype none

package u8vcf_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int RESULT_OFFSET_BITS = 32;
    localparam int CODE_BITS = 21;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_ENCODING = 2'd1,
        ST_BAD_CONTROL  = 2'd2
    } t_status;

    localparam logic [7:0] CONT_MASK   = 8'hc0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] ASCII_MAX   = 8'h7f;
    localparam logic [7:0] LEAD2_MIN   = 8'hc2;
    localparam logic [7:0] LEAD2_MAX   = 8'hdf;
    localparam logic [7:0] LEAD3_MIN   = 8'he0;
    localparam logic [7:0] LEAD3_MAX   = 8'hef;
    localparam logic [7:0] LEAD4_MIN   = 8'hf0;
    localparam logic [7:0] LEAD4_MAX   = 8'hf4;
    localparam logic [7:0] LEAD_E0     = 8'he0;
    localparam logic [7:0] LEAD_ED     = 8'hed;
    localparam logic [7:0] LEAD_F0     = 8'hf0;
    localparam logic [7:0] LEAD_F4     = 8'hf4;
    localparam logic [7:0] E0_LOW      = 8'ha0;
    localparam logic [7:0] ED_HIGH     = 8'h9f;
    localparam logic [7:0] F0_LOW      = 8'h90;
    localparam logic [7:0] F4_HIGH     = 8'h8f;

    localparam logic [CODE_BITS-1:0] CP_TAB      = CODE_BITS'(32'h09);
    localparam logic [CODE_BITS-1:0] CP_LF       = CODE_BITS'(32'h0a);
    localparam logic [CODE_BITS-1:0] CP_CR       = CODE_BITS'(32'h0d);
    localparam logic [CODE_BITS-1:0] CP_C0_MAX   = CODE_BITS'(32'h1f);
    localparam logic [CODE_BITS-1:0] CP_DEL      = CODE_BITS'(32'h7f);
    localparam logic [CODE_BITS-1:0] CP_C1_MAX   = CODE_BITS'(32'h9f);

    function automatic logic is_banned_control(input logic [CODE_BITS-1:0] cp);
        logic allowed;
        allowed = (cp == CP_TAB) || (cp == CP_LF) || (cp == CP_CR);
        return !allowed && ((cp <= CP_C0_MAX) || ((cp >= CP_DEL) && (cp <= CP_C1_MAX)));
    endfunction

endpackage

`default_nettype wire

### rtl/utf8_validator_control_filter_core.sv
// ----------------------------------------------------------------------------
// utf8_validator_control_filter_core
// Strict UTF-8 validator with a C0/C1 control character filter, one byte
// per item, giving one verdict with the first error offset at end of text.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Payload
//  -------  ---------  ----------------------  ----------------------------------
//  in       sink       i_in_valid / o_in_stall i_text_byte, i_byte_present,
//                                              i_end_of_text
//  out      source     o_out_valid / i_out_stall o_verdict, o_error_offset
//
//  One item per cycle is taken while o_in_stall is low. An item goes from the
//  input register through the decode and state update into the result register,
//  so a verdict is registered when its end-of-text item fires from the input register.
//  Reset clears the scan state and both valid flags; no clearing pass follows.
//  A stalled result blocks only an end-of-text item; other items keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validator_control_filter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_text_byte,
    input  wire logic        i_byte_present,
    input  wire logic        i_end_of_text,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_verdict,
    output logic [31:0]      o_error_offset
);
    import u8vcf_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    logic                   r_in_valid;
    logic [7:0]             r_text_byte;
    logic                   r_byte_present;
    logic                   r_end_of_text;

    logic [OFFSET_BITS-1:0] r_byte_count,     n_byte_count;
    logic [OFFSET_BITS-1:0] r_sequence_start, n_sequence_start;
    logic [1:0]             r_bytes_pending,  n_bytes_pending;
    logic [7:0]             r_lead_held,      n_lead_held;
    logic                   r_at_second_byte, n_at_second_byte;
    logic [CODE_BITS-1:0]   r_partial_code,   n_partial_code;
    t_status                r_latched_status, n_latched_status;
    logic [OFFSET_BITS-1:0] r_latched_offset, n_latched_offset;

    logic                   r_out_valid;
    logic [1:0]             r_verdict;
    logic [31:0]            r_error_offset;

    logic                   out_free;
    logic                   fire;
    logic                   good;
    logic [CODE_BITS-1:0]   next_code;
    logic [63:0]            wide_offset;
    logic [1:0]             res_verdict;
    logic [31:0]            res_offset;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!r_end_of_text || out_free);
    assign o_in_stall = r_in_valid && !fire;

    always_comb begin
        n_byte_count     = r_byte_count;
        n_sequence_start = r_sequence_start;
        n_bytes_pending  = r_bytes_pending;
        n_lead_held      = r_lead_held;
        n_at_second_byte = r_at_second_byte;
        n_partial_code   = r_partial_code;
        n_latched_status = r_latched_status;
        n_latched_offset = r_latched_offset;
        good             = ((r_text_byte & CONT_MASK) == CONT_TAG);
        next_code        = {r_partial_code[CODE_BITS-7:0], r_text_byte[5:0]};
        wide_offset      = '0;
        res_verdict      = 2'd0;
        res_offset       = '0;

        if (r_at_second_byte) begin
            if (r_lead_held == LEAD_E0 && r_text_byte < E0_LOW) begin
                good = 1'b0;
            end
            if (r_lead_held == LEAD_ED && r_text_byte > ED_HIGH) begin
                good = 1'b0;
            end
            if (r_lead_held == LEAD_F0 && r_text_byte < F0_LOW) begin
                good = 1'b0;
            end
            if (r_lead_held == LEAD_F4 && r_text_byte > F4_HIGH) begin
                good = 1'b0;
            end
        end

        if (r_byte_present) begin
            if (r_latched_status == ST_OK) begin
                if (r_bytes_pending == 2'd0) begin
                    if (r_text_byte <= ASCII_MAX) begin
                        if (is_banned_control(CODE_BITS'(r_text_byte))) begin
                            n_latched_status = ST_BAD_CONTROL;
                            n_latched_offset = r_byte_count;
                        end
                    end else if (r_text_byte >= LEAD2_MIN && r_text_byte <= LEAD2_MAX) begin
                        n_bytes_pending  = 2'd1;
                        n_partial_code   = CODE_BITS'(r_text_byte[4:0]);
                        n_lead_held      = r_text_byte;
                        n_at_second_byte = 1'b1;
                        n_sequence_start = r_byte_count;
                    end else if (r_text_byte >= LEAD3_MIN && r_text_byte <= LEAD3_MAX) begin
                        n_bytes_pending  = 2'd2;
                        n_partial_code   = CODE_BITS'(r_text_byte[3:0]);
                        n_lead_held      = r_text_byte;
                        n_at_second_byte = 1'b1;
                        n_sequence_start = r_byte_count;
                    end else if (r_text_byte >= LEAD4_MIN && r_text_byte <= LEAD4_MAX) begin
                        n_bytes_pending  = 2'd3;
                        n_partial_code   = CODE_BITS'(r_text_byte[2:0]);
                        n_lead_held      = r_text_byte;
                        n_at_second_byte = 1'b1;
                        n_sequence_start = r_byte_count;
                    end else begin
                        n_latched_status = ST_BAD_ENCODING;
                        n_latched_offset = r_byte_count;
                    end
                end else if (!good) begin
                    n_latched_status = ST_BAD_ENCODING;
                    n_latched_offset = r_sequence_start;
                    n_bytes_pending  = 2'd0;
                    n_at_second_byte = 1'b0;
                end else begin
                    n_partial_code   = next_code;
                    n_at_second_byte = 1'b0;
                    n_bytes_pending  = r_bytes_pending - 2'd1;
                    if (r_bytes_pending == 2'd1 && is_banned_control(next_code)) begin
                        n_latched_status = ST_BAD_CONTROL;
                        n_latched_offset = r_sequence_start;
                    end
                end
            end
            if (r_byte_count != OFFSET_MAX) begin
                n_byte_count = r_byte_count + OFFSET_BITS'(1);
            end
        end

        if (r_end_of_text) begin
            if (n_latched_status == ST_OK && n_bytes_pending != 2'd0) begin
                n_latched_status = ST_BAD_ENCODING;
                n_latched_offset = n_sequence_start;
            end
            wide_offset = 64'(n_latched_offset);
            res_verdict = n_latched_status;
            res_offset  = (n_latched_status == ST_OK) ? 32'd0 :
                          wide_offset[RESULT_OFFSET_BITS-1:0];
            n_byte_count     = '0;
            n_sequence_start = '0;
            n_bytes_pending  = 2'd0;
            n_lead_held      = 8'd0;
            n_at_second_byte = 1'b0;
            n_partial_code   = '0;
            n_latched_status = ST_OK;
            n_latched_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || fire) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || fire) begin
            r_text_byte    <= i_text_byte;
            r_byte_present <= i_byte_present;
            r_end_of_text  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count     <= '0;
            r_sequence_start <= '0;
            r_bytes_pending  <= 2'd0;
            r_lead_held      <= 8'd0;
            r_at_second_byte <= 1'b0;
            r_partial_code   <= '0;
            r_latched_status <= ST_OK;
            r_latched_offset <= '0;
        end else if (fire) begin
            r_byte_count     <= n_byte_count;
            r_sequence_start <= n_sequence_start;
            r_bytes_pending  <= n_bytes_pending;
            r_lead_held      <= n_lead_held;
            r_at_second_byte <= n_at_second_byte;
            r_partial_code   <= n_partial_code;
            r_latched_status <= n_latched_status;
            r_latched_offset <= n_latched_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_end_of_text) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_end_of_text) begin
            r_verdict      <= res_verdict;
            r_error_offset <= res_offset;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_error_offset = r_error_offset;

endmodule

`default_nettype wire

### test/utf8_validator_control_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_validator_control_filter_core_tb
// Self-checking testbench for the UTF-8 validator with control filter. Texts
// are sent one byte per item, from a short directed set and then as random
// texts of encoded code points with occasional corruption. A predictor in
// the testbench computes the verdict and error offset of each text, and a
// checker compares every result with the oldest prediction. Both sides idle
// and stall at random, and one long result stall backs the block up.
// ----------------------------------------------------------------------------

module utf8_validator_control_filter_core_tb;

    import u8vcf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        t_status     verdict;
        logic [31:0] offset;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_text_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_text = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_verdict;
    logic [31:0] o_error_offset;

    t_verdict expected_verdicts[$];
    logic [7:0] text_buf[$];

    // Predicted scan state of the text in progress.
    logic [OFFSET_BITS-1:0] byte_pos = '0;
    logic [OFFSET_BITS-1:0] seq_pos = '0;
    logic [OFFSET_BITS-1:0] err_pos = '0;
    logic [1:0]             cont_left = 2'd0;
    logic [7:0]             lead_byte = 8'h00;
    logic                   at_second = 1'b0;
    logic [CODE_BITS-1:0]   code_acc = '0;
    t_status                scan_status = ST_OK;

    int fail_count = 0;
    int cycle_count = 0;
    int text_items = 0;
    int clean_texts = 0;
    int encoding_errors = 0;
    int control_errors = 0;
    int burst_left = 0;
    bit steady = 1'b0;
    int hold_trigger = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int phase_left = 0;

    utf8_validator_control_filter_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_byte_present (i_byte_present),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_verdict      (o_verdict),
        .o_error_offset (o_error_offset)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic rejected_control(input logic [CODE_BITS-1:0] cp);
        if (cp == CP_TAB || cp == CP_LF || cp == CP_CR) begin
            return 1'b0;
        end
        return (cp <= CP_C0_MAX) || (cp >= CP_DEL && cp <= CP_C1_MAX);
    endfunction

    function automatic void flag_error(input t_status kind,
                                       input logic [OFFSET_BITS-1:0] pos);
        scan_status = kind;
        err_pos = pos;
        cont_left = 2'd0;
        at_second = 1'b0;
    endfunction

    function automatic void update_scan(input logic [7:0] b, input logic p,
                                        input logic e);
        logic     good;
        t_verdict v;
        if (p) begin
            if (scan_status == ST_OK) begin
                if (cont_left == 2'd0) begin
                    if (b <= ASCII_MAX) begin
                        if (rejected_control(CODE_BITS'(b))) begin
                            flag_error(ST_BAD_CONTROL, byte_pos);
                        end
                    end else begin
                        if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                            cont_left = 2'd1;
                            code_acc = CODE_BITS'(b[4:0]);
                        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                            cont_left = 2'd2;
                            code_acc = CODE_BITS'(b[3:0]);
                        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                            cont_left = 2'd3;
                            code_acc = CODE_BITS'(b[2:0]);
                        end
                        if (cont_left == 2'd0) begin
                            flag_error(ST_BAD_ENCODING, byte_pos);
                        end else begin
                            lead_byte = b;
                            at_second = 1'b1;
                            seq_pos = byte_pos;
                        end
                    end
                end else begin
                    good = (b & CONT_MASK) == CONT_TAG;
                    if (at_second) begin
                        if (lead_byte == LEAD_E0 && b < E0_LOW) good = 1'b0;
                        if (lead_byte == LEAD_ED && b > ED_HIGH) good = 1'b0;
                        if (lead_byte == LEAD_F0 && b < F0_LOW) good = 1'b0;
                        if (lead_byte == LEAD_F4 && b > F4_HIGH) good = 1'b0;
                    end
                    if (!good) begin
                        flag_error(ST_BAD_ENCODING, seq_pos);
                    end else begin
                        code_acc = {code_acc[CODE_BITS-7:0], b[5:0]};
                        at_second = 1'b0;
                        cont_left = cont_left - 2'd1;
                        if (cont_left == 2'd0 && rejected_control(code_acc)) begin
                            flag_error(ST_BAD_CONTROL, seq_pos);
                        end
                    end
                end
            end
            if (byte_pos != '1) begin
                byte_pos = byte_pos + OFFSET_BITS'(1);
            end
        end
        if (e) begin
            if (scan_status == ST_OK && cont_left != 2'd0) begin
                flag_error(ST_BAD_ENCODING, seq_pos);
            end
            v.verdict = scan_status;
            v.offset = (scan_status == ST_OK) ? 32'd0 : 32'(err_pos);
            expected_verdicts.push_back(v);
            byte_pos = '0;
            seq_pos = '0;
            err_pos = '0;
            cont_left = 2'd0;
            lead_byte = 8'h00;
            at_second = 1'b0;
            code_acc = '0;
            scan_status = ST_OK;
        end
    endfunction

    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        int gap;
        if (!steady && burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else if (burst_left > 0) begin
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_text_byte <= b;
        i_byte_present <= p;
        i_end_of_text <= e;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        update_scan(b, p, e);
        if (p || e) begin
            text_items++;
        end
    endtask

    task automatic send_text(input bit eot_separate, input int idle_odds);
        int last;
        last = text_buf.size() - 1;
        for (int i = 0; i <= last; i++) begin
            if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(text_buf[i], 1'b1, !eot_separate && i == last);
        end
        if (eot_separate || last < 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_text();
        logic [CODE_BITS-1:0] cp;
        int                   n_cp;
        int                   pos;
        logic [7:0]           lead;
        text_buf.delete();
        n_cp = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
        for (int k = 0; k < n_cp; k++) begin
            case ($urandom_range(0, 9))
                0: begin
                    if ($urandom_range(0, 3) == 0) begin
                        cp = CODE_BITS'($urandom_range(0, 'h9f));
                    end else begin
                        case ($urandom_range(0, 2))
                            0: cp = CP_TAB;
                            1: cp = CP_LF;
                            default: cp = CP_CR;
                        endcase
                    end
                end
                1, 2, 3: cp = CODE_BITS'($urandom_range('h20, 'h7e));
                4: cp = CODE_BITS'($urandom_range('h80, 'h7ff));
                5: cp = CODE_BITS'($urandom_range('h800, 'hffff));
                6: cp = CODE_BITS'($urandom_range('h10000, 'h10ffff));
                7: begin
                    case ($urandom_range(0, 9))
                        0: cp = 'h7f;
                        1: cp = 'h80;
                        2: cp = 'h9f;
                        3: cp = 'ha0;
                        4: cp = 'h7ff;
                        5: cp = 'h800;
                        6: cp = 'hd7ff;
                        7: cp = 'he000;
                        8: cp = 'hffff;
                        default: cp = $urandom_range(0, 1) ? 'h10000 : 'h10ffff;
                    endcase
                end
                default: cp = CODE_BITS'($urandom_range('h20, 'h7e));
            endcase
            if (cp < 'h80) begin
                text_buf.push_back(cp[7:0]);
            end else if (cp < 'h800) begin
                text_buf.push_back({3'b110, cp[10:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end else if (cp < 'h10000) begin
                text_buf.push_back({4'b1110, cp[15:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end else begin
                text_buf.push_back({5'b11110, cp[20:18]});
                text_buf.push_back({2'b10, cp[17:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
        end
        if (text_buf.size() > 0 && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
                1: text_buf.pop_back();
                default: begin
                    case ($urandom_range(0, 7))
                        0: lead = 8'hc0;
                        1: lead = 8'hc1;
                        2: lead = LEAD_E0;
                        3: lead = LEAD_ED;
                        4: lead = LEAD_F0;
                        5: lead = LEAD_F4;
                        6: lead = 8'hf5;
                        default: lead = 8'hff;
                    endcase
                    pos = $urandom_range(0, text_buf.size());
                    text_buf.insert(pos, lead);
                end
            endcase
        end
        steady = ($urandom_range(0, 4) == 0);
        send_text($urandom_range(0, 3) == 0, 12);
        steady = 1'b0;
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        text_buf = '{8'h09, 8'h0a, 8'h0d, 8'hf4, 8'h8f, 8'hbf, 8'hbf};
        send_text(1'b0, 0);
        text_buf = '{8'h41, 8'hff, 8'h00, 8'h80};
        send_text(1'b0, 0);
        text_buf = '{8'hed, 8'ha0};
        send_text(1'b0, 0);
        text_buf = '{8'hf0, 8'h8f};
        send_text(1'b0, 0);
        text_buf = '{8'he2, 8'h82};
        send_text(1'b1, 0);
        text_buf = '{8'hc2, 8'h9f};
        send_text(1'b0, 0);
        text_buf = '{8'h7f};
        send_text(1'b0, 0);
        wait_drained();
    endtask

    task automatic test_random_texts(input int n_items);
        int stop_at;
        stop_at = text_items + n_items;
        while (text_items < stop_at) send_random_text();
    endtask

    task automatic test_result_backpressure();
        wait_drained();
        hold_trigger++;
        steady = 1'b1;
        for (int k = 0; k < 24; k++) begin
            text_buf = '{8'($urandom_range('h20, 'h7e))};
            send_text(1'b0, 0);
        end
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_idle_pause();
        send_random_text();
        send_random_text();
        wait_drained();
        repeat ($urandom_range(5, 30)) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 120);
            end else begin
                phase_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                2: i_out_stall <= ~i_out_stall;
                default: i_out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_verdicts
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                $error("unexpected verdict %0d with offset %0d", o_verdict, o_error_offset);
                fail_count++;
            end else begin
                want = expected_verdicts.pop_front();
                case (want.verdict)
                    ST_OK: clean_texts++;
                    ST_BAD_ENCODING: encoding_errors++;
                    default: control_errors++;
                endcase
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, o_verdict);
                    fail_count++;
                end
                if (o_error_offset !== want.offset) begin
                    $error("error_offset: expected %0d, actual %0d",
                           want.offset, o_error_offset);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_texts(700);
        test_result_backpressure();
        test_idle_pause();
        test_random_texts(700);
        wait_drained();
        $display("Sent %0d text items; verdicts: %0d clean, %0d bad encoding, %0d bad control.",
                 text_items, clean_texts, encoding_errors, control_errors);
        $display("Random idling on both sides plus one %0d-cycle result stall.", HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
